// ----- rtl/core/dcsrb_pkg.sv -----
package dcsrb_pkg;

   localparam int RX_DEPTH_DEFAULT     = 64;
   localparam int TX_DEPTH_DEFAULT     = 64;
   localparam int NUM_CHANNELS_DEFAULT = 2;

   localparam int DATA_W   = 8;
   localparam int MODE_W   = 2;
   localparam int CHAN_W   = 2;
   localparam int STATUS_W = 3;
   localparam int REQ_USER_W = MODE_W + CHAN_W;
   localparam int RSP_USER_W = STATUS_W + 3;

   typedef enum logic [MODE_W-1:0] {
      MODE_RX_PUSH = 2'd0,
      MODE_RX_POP  = 2'd1,
      MODE_TX_PUSH = 2'd2,
      MODE_TX_POP  = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_RX_NODATA = 3'd1,
      ST_TX_FULL   = 3'd2,
      ST_TX_EMPTY  = 3'd3,
      ST_BAD_CH    = 3'd4,
      ST_RX_DROP   = 3'd5
   } status_type;

   typedef struct packed {
      logic load;
      logic exec;
   } cmd_type;

endpackage

// ----- rtl/core/dcsrb_ctrl.sv -----
module dcsrb_ctrl
   import dcsrb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   output cmd_type cmd
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_EXEC = 3'b010,
      S_RESP = 3'b100
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_RESP);
   assign cmd.load   = req_tvalid && (state_ff == S_IDLE);
   assign cmd.exec   = (state_ff == S_EXEC);

endmodule

// ----- rtl/core/dcsrb_datapath.sv -----
module dcsrb_datapath
   import dcsrb_pkg::*;
#(
   parameter int RX_DEPTH     = RX_DEPTH_DEFAULT,
   parameter int TX_DEPTH     = TX_DEPTH_DEFAULT,
   parameter int NUM_CHANNELS = NUM_CHANNELS_DEFAULT
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   input  logic [DATA_W-1:0]     req_tdata,
   input  logic [REQ_USER_W-1:0] req_tuser,
   output logic [DATA_W-1:0]     rsp_tdata,
   output logic [RSP_USER_W-1:0] rsp_tuser
);

   localparam int RX_IW = $clog2(RX_DEPTH);
   localparam int TX_IW = $clog2(TX_DEPTH);
   localparam int RX_CW = $clog2(RX_DEPTH + 1);
   localparam int TX_CW = $clog2(TX_DEPTH + 1);
   localparam int RX_AW = $clog2(NUM_CHANNELS * RX_DEPTH);
   localparam int TX_AW = $clog2(NUM_CHANNELS * TX_DEPTH);
   localparam int CH_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

   localparam logic [RX_CW-1:0] RX_FULL = RX_CW'(RX_DEPTH);
   localparam logic [TX_CW-1:0] TX_FULL = TX_CW'(TX_DEPTH);
   localparam logic [RX_IW-1:0] RX_LAST = RX_IW'(RX_DEPTH - 1);
   localparam logic [TX_IW-1:0] TX_LAST = TX_IW'(TX_DEPTH - 1);
   localparam logic [RX_AW-1:0] RX_BASE = RX_AW'(RX_DEPTH);
   localparam logic [TX_AW-1:0] TX_BASE = TX_AW'(TX_DEPTH);

   logic [DATA_W-1:0] rx_mem [NUM_CHANNELS * RX_DEPTH];
   logic [DATA_W-1:0] tx_mem [NUM_CHANNELS * TX_DEPTH];

   logic [RX_CW-1:0] rx_count_ff [NUM_CHANNELS];
   logic [TX_CW-1:0] tx_count_ff [NUM_CHANNELS];
   logic [RX_IW-1:0] rx_wr_ff    [NUM_CHANNELS];
   logic [RX_IW-1:0] rx_rd_ff    [NUM_CHANNELS];
   logic [TX_IW-1:0] tx_wr_ff    [NUM_CHANNELS];
   logic [TX_IW-1:0] tx_rd_ff    [NUM_CHANNELS];

   mode_type          mode_ff;
   logic [CHAN_W-1:0] channel_ff;
   logic [DATA_W-1:0] data_in_ff;

   status_type        status_ff, status_in;
   logic              rx_empty_ff, rx_empty_in;
   logic              tx_full_ff, tx_full_in;
   logic              tx_start_ff;
   logic              pop_rx_ff, pop_tx_ff;
   logic [DATA_W-1:0] rx_q_ff, tx_q_ff;

   logic [CH_W-1:0]  ch_sel;
   logic             ch_ok;
   logic [RX_CW-1:0] rx_cnt_cur, rx_cnt_new;
   logic [TX_CW-1:0] tx_cnt_cur, tx_cnt_new;
   logic             rx_push, rx_pop, tx_push, tx_pop;
   logic [RX_AW-1:0] rx_wr_addr, rx_rd_addr;
   logic [TX_AW-1:0] tx_wr_addr, tx_rd_addr;

   assign ch_sel     = CH_W'(channel_ff);
   assign ch_ok      = (channel_ff < CHAN_W'(NUM_CHANNELS));
   assign rx_cnt_cur = rx_count_ff[ch_sel];
   assign tx_cnt_cur = tx_count_ff[ch_sel];

   assign rx_push = ch_ok && (mode_ff == MODE_RX_PUSH) && (rx_cnt_cur != RX_FULL);
   assign rx_pop  = ch_ok && (mode_ff == MODE_RX_POP)  && (rx_cnt_cur != '0);
   assign tx_push = ch_ok && (mode_ff == MODE_TX_PUSH) && (tx_cnt_cur != TX_FULL);
   assign tx_pop  = ch_ok && (mode_ff == MODE_TX_POP)  && (tx_cnt_cur != '0);

   assign rx_wr_addr = (ch_sel != '0) ? RX_BASE + RX_AW'(rx_wr_ff[ch_sel])
                                      : RX_AW'(rx_wr_ff[ch_sel]);
   assign rx_rd_addr = (ch_sel != '0) ? RX_BASE + RX_AW'(rx_rd_ff[ch_sel])
                                      : RX_AW'(rx_rd_ff[ch_sel]);
   assign tx_wr_addr = (ch_sel != '0) ? TX_BASE + TX_AW'(tx_wr_ff[ch_sel])
                                      : TX_AW'(tx_wr_ff[ch_sel]);
   assign tx_rd_addr = (ch_sel != '0) ? TX_BASE + TX_AW'(tx_rd_ff[ch_sel])
                                      : TX_AW'(tx_rd_ff[ch_sel]);

   always_comb begin
      rx_cnt_new = rx_cnt_cur;
      tx_cnt_new = tx_cnt_cur;
      if (rx_push) begin
         rx_cnt_new = rx_cnt_cur + RX_CW'(1);
      end else if (rx_pop) begin
         rx_cnt_new = rx_cnt_cur - RX_CW'(1);
      end
      if (tx_push) begin
         tx_cnt_new = tx_cnt_cur + TX_CW'(1);
      end else if (tx_pop) begin
         tx_cnt_new = tx_cnt_cur - TX_CW'(1);
      end
   end

   always_comb begin
      status_in = ST_OK;
      case (mode_ff)
         MODE_RX_PUSH: begin
            if (!rx_push) begin
               status_in = ST_RX_DROP;
            end
         end
         MODE_RX_POP: begin
            if (!rx_pop) begin
               status_in = ST_RX_NODATA;
            end
         end
         MODE_TX_PUSH: begin
            if (!tx_push) begin
               status_in = ST_TX_FULL;
            end
         end
         MODE_TX_POP: begin
            if (!tx_pop) begin
               status_in = ST_TX_EMPTY;
            end
         end
         default: begin
            status_in = ST_OK;
         end
      endcase
      if (!ch_ok) begin
         status_in = ST_BAD_CH;
      end
      rx_empty_in = !ch_ok || (rx_cnt_new == '0);
      tx_full_in  = !ch_ok || (tx_cnt_new == TX_FULL);
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff    <= mode_type'(req_tuser[MODE_W-1:0]);
         channel_ff <= req_tuser[REQ_USER_W-1:MODE_W];
         data_in_ff <= req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec && rx_push) begin
         rx_mem[rx_wr_addr] <= data_in_ff;
      end
      if (cmd.exec) begin
         rx_q_ff <= rx_mem[rx_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec && tx_push) begin
         tx_mem[tx_wr_addr] <= data_in_ff;
      end
      if (cmd.exec) begin
         tx_q_ff <= tx_mem[tx_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         status_ff   <= status_in;
         rx_empty_ff <= rx_empty_in;
         tx_full_ff  <= tx_full_in;
         tx_start_ff <= tx_push && (tx_cnt_cur == '0);
         pop_rx_ff   <= rx_pop;
         pop_tx_ff   <= tx_pop;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            rx_count_ff[i] <= '0;
            tx_count_ff[i] <= '0;
            rx_wr_ff[i]    <= '0;
            rx_rd_ff[i]    <= '0;
            tx_wr_ff[i]    <= '0;
            tx_rd_ff[i]    <= '0;
         end
      end else if (cmd.exec && ch_ok) begin
         rx_count_ff[ch_sel] <= rx_cnt_new;
         tx_count_ff[ch_sel] <= tx_cnt_new;
         if (rx_push) begin
            rx_wr_ff[ch_sel] <= (rx_wr_ff[ch_sel] == RX_LAST) ? '0
                                : rx_wr_ff[ch_sel] + RX_IW'(1);
         end
         if (rx_pop) begin
            rx_rd_ff[ch_sel] <= (rx_rd_ff[ch_sel] == RX_LAST) ? '0
                                : rx_rd_ff[ch_sel] + RX_IW'(1);
         end
         if (tx_push) begin
            tx_wr_ff[ch_sel] <= (tx_wr_ff[ch_sel] == TX_LAST) ? '0
                                : tx_wr_ff[ch_sel] + TX_IW'(1);
         end
         if (tx_pop) begin
            tx_rd_ff[ch_sel] <= (tx_rd_ff[ch_sel] == TX_LAST) ? '0
                                : tx_rd_ff[ch_sel] + TX_IW'(1);
         end
      end
   end

   assign rsp_tdata = pop_rx_ff ? rx_q_ff : (pop_tx_ff ? tx_q_ff : '0);
   assign rsp_tuser = {tx_start_ff, tx_full_ff, rx_empty_ff, status_ff};

endmodule

// ----- rtl/core/dual_channel_serial_ring_buffers_core.sv -----
// Receive and transmit byte FIFOs for up to two serial channels.
// The request channel carries one operation per transfer: req_tuser selects
// the operation (receiver push, application pop, application push,
// transmitter pop) and the channel, and req_tdata carries the byte to push.
// The response channel returns exactly one transfer per request with the
// popped byte on rsp_tdata and the status code, the receive-empty flag, the
// transmit-full flag and the transmit-start pulse on rsp_tuser.
// A request is taken only while no other is in flight. After the request
// transfer the controller passes through its execute state, where the byte
// stores are read and their read data is registered, and then presents the
// response in its response state.
// While rsp_tready is low the response holds steady and no new request is
// taken. Reset empties all buffers of both channels at once; the byte
// stores themselves are not cleared, since no entry is read before it is
// written.
module dual_channel_serial_ring_buffers_core
   import dcsrb_pkg::*;
#(
   parameter int RX_DEPTH     = RX_DEPTH_DEFAULT,
   parameter int TX_DEPTH     = TX_DEPTH_DEFAULT,
   parameter int NUM_CHANNELS = NUM_CHANNELS_DEFAULT
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // Fields from bit 0: data_in[7:0].
   input  logic [DATA_W-1:0]     req_tdata,
   // Fields from bit 0: mode[1:0], channel[3:2].
   input  logic [REQ_USER_W-1:0] req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // Fields from bit 0: data_out[7:0].
   output logic [DATA_W-1:0]     rsp_tdata,
   // Fields from bit 0: status[2:0], rx_empty[3], tx_full[4], tx_start[5].
   output logic [RSP_USER_W-1:0] rsp_tuser
);

   cmd_type cmd;

   dcsrb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   dcsrb_datapath #(
      .RX_DEPTH     (RX_DEPTH),
      .TX_DEPTH     (TX_DEPTH),
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule

// ----- rtl/core/dcsrb_checker.sv -----
module dcsrb_checker
   import dcsrb_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [DATA_W-1:0]     rsp_tdata,
   input logic [RSP_USER_W-1:0] rsp_tuser
);

   logic req_fire;

   assign req_fire = req_tvalid && req_tready;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("Stalled response changed.");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_tready && !rsp_tvalid ##1 rsp_tvalid)
      else $error("Request transfer did not yield a single response in order.");

   a_bad_channel: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser[STATUS_W-1:0] == ST_BAD_CH) |->
         rsp_tuser[3] && rsp_tuser[4] && !rsp_tuser[5] && (rsp_tdata == '0))
      else $error("Bad channel response has wrong flags.");

   a_tx_start: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[5] |-> (rsp_tuser[STATUS_W-1:0] == ST_OK) && !rsp_tuser[4])
      else $error("Transmit start without a successful push.");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("Response valid right after reset.");

endmodule

bind dual_channel_serial_ring_buffers_core dcsrb_checker u_dcsrb_checker (.*);

// ----- tb/sv/testbench.sv -----
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import dcsrb_pkg::*;

   localparam int NCH         = NUM_CHANNELS_DEFAULT;
   localparam int RXD         = RX_DEPTH_DEFAULT;
   localparam int TXD         = TX_DEPTH_DEFAULT;
   localparam int STALL_LIMIT = 2000;
   localparam int HOLD_LONG   = 400;
   localparam int HOLD_CYCLE  = 3000;
   localparam int ITEM_TARGET = 1224;

   typedef struct {
      logic [DATA_W-1:0] data;
      status_type        status;
      logic              rx_empty;
      logic              tx_full;
      logic              tx_start;
   } serial_rsp_type;

   class ring_scoreboard_type;
      logic [DATA_W-1:0] rx_mem [NCH][RXD];
      logic [DATA_W-1:0] tx_mem [NCH][TXD];
      int rx_cnt [NCH];
      int rx_wr  [NCH];
      int rx_rd  [NCH];
      int tx_cnt [NCH];
      int tx_wr  [NCH];
      int tx_rd  [NCH];
      serial_rsp_type expected_q [$];
      int mismatches;
      int checked;

      function new();
         for (int c = 0; c < NCH; c++) begin
            rx_cnt[c] = 0;
            rx_wr[c]  = 0;
            rx_rd[c]  = 0;
            tx_cnt[c] = 0;
            tx_wr[c]  = 0;
            tx_rd[c]  = 0;
         end
         mismatches = 0;
         checked    = 0;
      endfunction

      function void note_request(mode_type m, logic [CHAN_W-1:0] ch,
                                 logic [DATA_W-1:0] din);
         serial_rsp_type r;
         int c;
         r.data     = '0;
         r.status   = ST_OK;
         r.rx_empty = 1'b1;
         r.tx_full  = 1'b1;
         r.tx_start = 1'b0;
         if (ch >= NCH) begin
            r.status = ST_BAD_CH;
            expected_q.push_back(r);
            return;
         end
         c = int'(ch);
         case (m)
            MODE_RX_PUSH: begin
               if (rx_cnt[c] < RXD) begin
                  rx_mem[c][rx_wr[c]] = din;
                  rx_wr[c] = (rx_wr[c] + 1) % RXD;
                  rx_cnt[c]++;
               end else begin
                  r.status = ST_RX_DROP;
               end
            end
            MODE_RX_POP: begin
               if (rx_cnt[c] > 0) begin
                  r.data = rx_mem[c][rx_rd[c]];
                  rx_rd[c] = (rx_rd[c] + 1) % RXD;
                  rx_cnt[c]--;
               end else begin
                  r.status = ST_RX_NODATA;
               end
            end
            MODE_TX_PUSH: begin
               if (tx_cnt[c] < TXD) begin
                  tx_mem[c][tx_wr[c]] = din;
                  tx_wr[c] = (tx_wr[c] + 1) % TXD;
                  tx_cnt[c]++;
                  r.tx_start = (tx_cnt[c] == 1);
               end else begin
                  r.status = ST_TX_FULL;
               end
            end
            default: begin
               if (tx_cnt[c] > 0) begin
                  r.data = tx_mem[c][tx_rd[c]];
                  tx_rd[c] = (tx_rd[c] + 1) % TXD;
                  tx_cnt[c]--;
               end else begin
                  r.status = ST_TX_EMPTY;
               end
            end
         endcase
         r.rx_empty = (rx_cnt[c] == 0);
         r.tx_full  = (tx_cnt[c] >= TXD);
         expected_q.push_back(r);
      endfunction

      function void flag(string what);
         mismatches++;
         if (mismatches <= 10) $display("mismatch: %s", what);
      endfunction

      function void check_response(logic [DATA_W-1:0] data, logic [RSP_USER_W-1:0] user);
         serial_rsp_type e;
         checked++;
         if (expected_q.size() == 0) begin
            flag($sformatf("response data=%0d user=%0h with no request outstanding",
                           data, user));
            return;
         end
         e = expected_q.pop_front();
         if (data !== e.data || user[2:0] !== e.status || user[3] !== e.rx_empty ||
             user[4] !== e.tx_full || user[5] !== e.tx_start) begin
            flag($sformatf({"expected data=%0d status=%0d rx_empty=%0b tx_full=%0b",
                            " tx_start=%0b, got data=%0d status=%0d rx_empty=%0b",
                            " tx_full=%0b tx_start=%0b"},
                           e.data, e.status, e.rx_empty, e.tx_full, e.tx_start,
                           data, user[2:0], user[3], user[4], user[5]));
         end
      endfunction
   endclass

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [DATA_W-1:0]     req_tdata  = '0;
   logic [REQ_USER_W-1:0] req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [DATA_W-1:0]     rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;

   bit quiet = 1'b0;
   int sent_count = 0;
   ring_scoreboard_type book = new();

   dual_channel_serial_ring_buffers_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5ns clock = ~clock;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   task automatic send_req(input mode_type m, input logic [CHAN_W-1:0] ch,
                           input logic [DATA_W-1:0] d);
      int gap;
      gap = quiet ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      req_tuser  <= {ch, m};
      do @(posedge clock); while (!req_tready);
      sent_count++;
   endtask

   // A burst leans on one channel, and most bursts on one operation, so that the
   // buffers really fill up and drain, with bad channels and other operations mixed in.
   task automatic random_burst();
      int kind;
      int focus;
      int len;
      int r;
      mode_type m;
      logic [CHAN_W-1:0] ch;
      kind  = $urandom_range(4);
      focus = $urandom_range(NCH - 1);
      len   = $urandom_range(60, 160);
      quiet = ($urandom_range(4) == 0);
      repeat (len) begin
         r = $urandom_range(99);
         if (r < 8) ch = CHAN_W'($urandom_range(3, NCH));
         else if (r < 25) ch = CHAN_W'($urandom_range(NCH - 1));
         else ch = CHAN_W'(focus);
         m = mode_type'($urandom_range(3));
         if (kind != 0 && $urandom_range(99) < 75) m = mode_type'(kind - 1);
         send_req(m, ch, DATA_W'($urandom_range(255)));
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      send_req(MODE_RX_POP,  2'd0, 8'h00);
      send_req(MODE_TX_POP,  2'd0, 8'hFF);
      send_req(MODE_TX_PUSH, 2'd0, 8'h00);
      send_req(MODE_TX_PUSH, 2'd0, 8'hFF);
      send_req(MODE_TX_POP,  2'd0, 8'h00);
      send_req(MODE_TX_POP,  2'd0, 8'h00);
      send_req(MODE_TX_POP,  2'd0, 8'h00);
      send_req(MODE_RX_PUSH, 2'd1, 8'hFF);
      send_req(MODE_RX_PUSH, 2'd1, 8'h00);
      send_req(MODE_RX_POP,  2'd1, 8'h00);
      send_req(MODE_RX_POP,  2'd1, 8'h00);
      send_req(MODE_RX_POP,  2'd1, 8'h00);
      for (int bad = NCH; bad < 4; bad++) begin
         send_req(MODE_RX_PUSH, CHAN_W'(bad), 8'hA5);
         send_req(MODE_RX_POP,  CHAN_W'(bad), 8'h5A);
         send_req(MODE_TX_PUSH, CHAN_W'(bad), 8'hFF);
         send_req(MODE_TX_POP,  CHAN_W'(bad), 8'h00);
      end
      send_req(MODE_RX_PUSH, 2'd0, 8'h55);
      send_req(MODE_TX_PUSH, 2'd1, 8'hAA);
      send_req(MODE_RX_POP,  2'd0, 8'h00);
      send_req(MODE_TX_POP,  2'd1, 8'h00);

      while (sent_count < ITEM_TARGET) random_burst();
      req_tvalid <= 1'b0;

      while (book.checked < sent_count) @(posedge clock);
      repeat (10) @(posedge clock);
      if (book.mismatches == 0 && book.expected_q.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // The long hold-off stalls the response, so the block stalls its input while
   // requests keep being offered.
   initial begin
      int hold;
      int cycles;
      int r;
      hold   = 0;
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles == HOLD_CYCLE) begin
            hold = HOLD_LONG;
         end else if (hold == 0 && !quiet) begin
            r = $urandom_range(99);
            if (r < 20) hold = $urandom_range(1, 3);
            else if (r < 24) hold = $urandom_range(4, 12);
            else if (r < 25) hold = $urandom_range(20, 40);
         end
         if (hold > 0) begin
            hold--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      int idle;
      idle = 0;
      while (idle < STALL_LIMIT) begin
         @(posedge clock);
         idle++;
         if (!reset && req_tvalid && req_tready) begin
            book.note_request(mode_type'(req_tuser[1:0]), req_tuser[3:2], req_tdata);
            idle = 0;
         end
         if (!reset && rsp_tvalid && rsp_tready) begin
            book.check_response(rsp_tdata, rsp_tuser);
            idle = 0;
         end
      end
      $display("FAILURE");
      $finish;
   end

endmodule
